FILE: src/hdpk_pkg.sv
// Shared types, codes and helpers of the H.264/H.265 NAL depacketizer.
package hdpk_pkg;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RTP      = 4'd1,
      PH_HEAD     = 4'd2,
      PH_SINGLE   = 4'd3,
      PH_FU_HDR   = 4'd4,
      PH_FU_BODY  = 4'd5,
      PH_STAP_HI  = 4'd6,
      PH_STAP_LO  = 4'd7,
      PH_SUB_HEAD = 4'd8,
      PH_SUB_SKIP = 4'd9,
      PH_SKIP     = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      ROUTE_DROP = 2'd0,
      ROUTE_H264 = 2'd1,
      ROUTE_H265 = 2'd2,
      ROUTE_RAW  = 2'd3
   } route_type;

   typedef enum logic [1:0] {
      DET_NONE = 2'd0,
      DET_H264 = 2'd1,
      DET_H265 = 2'd2
   } det_type;

   localparam logic [1:0] KIND_PIC = 2'd0;
   localparam logic [1:0] KIND_VPS = 2'd1;
   localparam logic [1:0] KIND_SPS = 2'd2;
   localparam logic [1:0] KIND_PPS = 2'd3;

   localparam logic CODEC_264 = 1'b0;
   localparam logic CODEC_265 = 1'b1;

   localparam logic [4:0] NAL_IDR    = 5'd5;
   localparam logic [4:0] NAL_SPS    = 5'd7;
   localparam logic [4:0] NAL_PPS    = 5'd8;
   localparam logic [4:0] NAL_STAP_A = 5'd24;
   localparam logic [4:0] NAL_FU_A   = 5'd28;
   localparam logic [5:0] HEVC_VPS   = 6'd32;
   localparam logic [5:0] HEVC_SPS   = 6'd33;
   localparam logic [5:0] HEVC_PPS   = 6'd34;
   localparam logic [6:0] PT_H264    = 7'd96;
   localparam logic [6:0] PT_H265    = 7'd97;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPW         = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        has_byte;
      logic        unit_start;
      logic        unit_end;
      logic        unit_dropped;
      logic        codec;
      logic [1:0]  unit_kind;
      logic        keyframe;
      logic [31:0] timestamp;
   } res_type;

   function automatic res_type mk_res(logic [7:0] b, logic has, logic st, logic en,
                                      logic dr, logic codec, logic [1:0] kind,
                                      logic key, logic [31:0] ts);
      res_type r;
      r.out_byte     = b;
      r.has_byte     = has;
      r.unit_start   = st;
      r.unit_end     = en;
      r.unit_dropped = dr;
      r.codec        = codec;
      r.unit_kind    = kind;
      r.keyframe     = key;
      r.timestamp    = ts;
      return r;
   endfunction

endpackage

FILE: src/hdpk_if.sv
// Valid/ready channel interfaces for packet bytes in and NAL items out.
interface hdpk_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [13:0] packet_length;
   logic        first_of_packet;
   modport source (output valid, data_byte, packet_length, first_of_packet, input ready);
   modport sink   (input valid, data_byte, packet_length, first_of_packet, output ready);
endinterface

interface hdpk_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        has_byte;
   logic        unit_start;
   logic        unit_end;
   logic        unit_dropped;
   logic        codec;
   logic [1:0]  unit_kind;
   logic        keyframe;
   logic [31:0] timestamp;
   modport source (output valid, out_byte, has_byte, unit_start, unit_end, unit_dropped,
                   codec, unit_kind, keyframe, timestamp, input ready);
   modport sink   (input valid, out_byte, has_byte, unit_start, unit_end, unit_dropped,
                   codec, unit_kind, keyframe, timestamp, output ready);
endinterface

FILE: src/rtp_h26x_nal_depacketizer_top.sv
// Top level of the RTP H.264/H.265 NAL unit depacketizer.
//
// req_chan carries one packet byte per beat, with the packet length and a
// first-of-packet flag. rsp_chan carries NAL unit items: a byte, or a
// marker-only item, flagged start, end or dropped, with codec, kind,
// keyframe and RTP timestamp. csr_wr_en/csr_wr_data write auto_detect.
//
// Each accepted byte is parsed in the cycle it is accepted and yields zero,
// one or two items, which enter a four-entry result queue. An item is
// registered in the queue before it is visible on rsp_chan. One byte per
// cycle is taken as long as the queue has room for two items, so a stream
// of one item per byte, with rsp_chan always ready, runs at one beat per cycle.
//
// Reset clears all parse state, empties the queue and sets auto_detect.
// When the receiver stalls, the queue fills and req_chan.ready drops until
// space frees; no item is lost or repeated.
module rtp_h26x_nal_depacketizer_top import hdpk_pkg::*; #(
   parameter int MAX_UNIT_BYTES   = 262144,
   parameter int MAX_PACKET_BYTES = 16384
) (
   input  logic       clock,
   input  logic       reset,
   hdpk_req_if.sink   req_chan,
   hdpk_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic       auto_ff;
   logic       room, step;
   logic [1:0] n_push, n_gated;
   res_type    r0, r1, item;

   assign req_chan.ready = room;
   assign step           = req_chan.valid && room;
   assign n_gated        = step ? n_push : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) auto_ff <= 1'b1;
      else if (csr_wr_en) auto_ff <= csr_wr_data;
   end

   hdpk_parser #(
      .MAX_UNIT_BYTES   (MAX_UNIT_BYTES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .b           (req_chan.data_byte),
      .len         (req_chan.packet_length),
      .first       (req_chan.first_of_packet),
      .auto_detect (auto_ff),
      .n_push      (n_push),
      .r0          (r0),
      .r1          (r1)
   );

   hdpk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .n_push    (n_gated),
      .r0        (r0),
      .r1        (r1),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (item)
   );

   assign rsp_chan.out_byte     = item.out_byte;
   assign rsp_chan.has_byte     = item.has_byte;
   assign rsp_chan.unit_start   = item.unit_start;
   assign rsp_chan.unit_end     = item.unit_end;
   assign rsp_chan.unit_dropped = item.unit_dropped;
   assign rsp_chan.codec        = item.codec;
   assign rsp_chan.unit_kind    = item.unit_kind;
   assign rsp_chan.keyframe     = item.keyframe;
   assign rsp_chan.timestamp    = item.timestamp;

endmodule

FILE: src/hdpk_parser.sv
// Per-byte RTP/NAL parser: state registers and the update for one accepted beat.
module hdpk_parser import hdpk_pkg::*; #(
   parameter int MAX_UNIT_BYTES   = 262144,
   parameter int MAX_PACKET_BYTES = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  b,
   input  logic [13:0] len,
   input  logic        first,
   input  logic        auto_detect,
   output logic [1:0]  n_push,
   output res_type     r0,
   output res_type     r1
);

   localparam int FLW = $clog2(MAX_UNIT_BYTES + 1);
   localparam int SW  = ((FLW > 14) ? FLW : 14) + 1;

   logic [13:0]    pos_ff, pos_in;
   phase_type      phase_ff, phase_in;
   logic [18:0]    hdr_len_ff, hdr_len_in;
   logic [15:0]    last_seq_ff, last_seq_in;
   logic [31:0]    ts_ff, ts_in;
   route_type      route_ff, route_in;
   det_type        det_ff, det_in;
   logic [7:0]     nal_first_ff, nal_first_in;
   logic [15:0]    sub_rem_ff, sub_rem_in;
   logic           frag_open_ff, frag_open_in;
   logic [FLW-1:0] frag_len_ff, frag_len_in;
   logic           frag_key_ff, frag_key_in;
   logic           skip_ff, skip_in;
   logic [13:0]    pkt_len_ff, pkt_len_in;
   logic           ext_ff, ext_in;
   logic [7:0]     acc_ff, acc_in;
   logic           live_ff, live_in;
   logic           stap_ff, stap_in;
   logic           fu_end_ff, fu_end_in;
   logic           cur_codec_ff, cur_codec_in;
   logic [1:0]     cur_kind_ff, cur_kind_in;
   logic           cur_key_ff, cur_key_in;

   always_comb begin
      logic [13:0] after;
      logic        do_264, do_265, do_single, h_stap, s_stap, s_codec, s_key, hdr, now_end;
      logic        en, hd_check, no_step;
      logic [15:0] h_len, s_len, seq, size;
      logic [1:0]  s_kind;
      logic [4:0]  t5;
      logic [5:0]  t6;
      logic [SW-1:0] fsum;

      pos_in = pos_ff; phase_in = phase_ff; hdr_len_in = hdr_len_ff;
      last_seq_in = last_seq_ff; ts_in = ts_ff; route_in = route_ff; det_in = det_ff;
      nal_first_in = nal_first_ff; sub_rem_in = sub_rem_ff; frag_open_in = frag_open_ff;
      frag_len_in = frag_len_ff; frag_key_in = frag_key_ff; skip_in = skip_ff;
      pkt_len_in = pkt_len_ff; ext_in = ext_ff; acc_in = acc_ff; live_in = live_ff;
      stap_in = stap_ff; fu_end_in = fu_end_ff; cur_codec_in = cur_codec_ff;
      cur_kind_in = cur_kind_ff; cur_key_in = cur_key_ff;
      n_push = 2'd0; r0 = '0; r1 = '0;
      do_264 = 1'b0; do_265 = 1'b0; do_single = 1'b0; h_stap = 1'b0; h_len = '0;
      s_len = '0; s_stap = 1'b0; s_codec = 1'b0; s_kind = KIND_PIC; s_key = 1'b0;
      hdr = 1'b0; now_end = 1'b0; en = 1'b0; hd_check = 1'b0; no_step = 1'b0;
      seq = '0; size = '0; fsum = '0;
      t5 = b[4:0]; t6 = b[6:1];
      after = (15'(pkt_len_ff) > 15'(pos_ff) + 15'd1) ? pkt_len_ff - pos_ff - 14'd1 : '0;

      if (first) begin
         if (phase_ff != PH_IDLE) begin
            if (live_ff) begin
               r0 = mk_res(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, cur_codec_ff, cur_kind_ff,
                           cur_key_ff, ts_in);
               n_push = 2'd1;
            end else if (frag_open_ff && (phase_ff == PH_FU_HDR || phase_ff == PH_FU_BODY)) begin
               r0 = mk_res(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, CODEC_264, KIND_PIC,
                           frag_key_ff, ts_in);
               n_push = 2'd1;
               frag_open_in = 1'b0; frag_len_in = '0; fu_end_in = 1'b0; skip_in = 1'b0;
            end
         end
         live_in = 1'b0; stap_in = 1'b0; ext_in = 1'b0; pos_in = '0;
         pkt_len_in = len; route_in = ROUTE_DROP;
         if (len < 14'd12 || 32'(len) > MAX_PACKET_BYTES) begin
            phase_in = PH_SKIP;
         end else if (b[7:6] == 2'b10) begin
            phase_in = PH_RTP;
            hdr_len_in = 19'd12 + 19'({b[3:0], 2'b00});
            ext_in = b[4];
         end else if (det_ff == DET_H264 || auto_detect) begin
            route_in = ROUTE_RAW; ts_in = '0; hdr_len_in = '0;
            do_264 = 1'b1; h_len = 16'(len); h_stap = 1'b0;
         end else begin
            phase_in = PH_SKIP;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: no_step = 1'b1;
            PH_RTP: begin
               if (pos_ff == 14'd1) begin
                  route_in = (b[6:0] == PT_H264) ? ROUTE_H264 :
                             (b[6:0] == PT_H265) ? ROUTE_H265 : ROUTE_DROP;
               end else if (pos_ff == 14'd2) begin
                  acc_in = b;
               end else if (pos_ff == 14'd3) begin
                  seq = {acc_ff, b};
                  if (last_seq_ff != 16'd0 && seq != last_seq_ff + 16'd1) begin
                     if (frag_open_ff) begin
                        r0 = mk_res(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, CODEC_264, KIND_PIC,
                                    frag_key_ff, ts_in);
                        n_push = 2'd1;
                     end
                     frag_open_in = 1'b0; frag_len_in = '0; fu_end_in = 1'b0; skip_in = 1'b0;
                  end
                  last_seq_in = seq;
                  if (ext_ff) begin
                     if (20'(pkt_len_ff) < 20'(hdr_len_ff) + 20'd4) phase_in = PH_SKIP;
                  end else begin
                     hd_check = 1'b1;
                  end
               end else if (pos_ff >= 14'd4 && pos_ff <= 14'd7) begin
                  ts_in = {ts_ff[23:0], b};
               end else if (ext_ff && 20'(pos_ff) == 20'(hdr_len_ff) + 20'd2) begin
                  acc_in = b;
               end else if (ext_ff && 20'(pos_ff) == 20'(hdr_len_ff) + 20'd3) begin
                  hdr_len_in = hdr_len_ff + 19'd4 + 19'({acc_ff, b, 2'b00});
                  ext_in = 1'b0;
                  hd_check = 1'b1;
               end
               // header complete: pick codec or give up on the payload
               if (hd_check) begin
                  if (19'(pkt_len_ff) <= hdr_len_in || route_in == ROUTE_DROP)
                     phase_in = PH_SKIP;
                  else
                     det_in = (route_in == ROUTE_H264) ? DET_H264 : DET_H265;
               end
               if (phase_in == PH_RTP && !ext_in && 20'(pos_ff) + 20'd1 == 20'(hdr_len_in))
                  phase_in = PH_HEAD;
            end
            PH_HEAD: begin
               h_len = 16'(pkt_len_ff - pos_ff);
               if (route_ff == ROUTE_H265) do_265 = 1'b1;
               else do_264 = 1'b1;
            end
            PH_SINGLE: begin
               sub_rem_in = sub_rem_ff - 16'd1;
               en = (sub_rem_in == 16'd0);
               r0 = mk_res(b, 1'b1, 1'b0, en, 1'b0, cur_codec_ff, cur_kind_ff,
                           cur_key_ff, ts_in);
               n_push = 2'd1;
               if (en) begin
                  live_in = 1'b0;
                  phase_in = stap_ff ? PH_STAP_HI : PH_SKIP;
               end
            end
            PH_FU_HDR: begin
               if (b[7]) begin
                  if (frag_open_ff) begin
                     r0 = mk_res(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, CODEC_264, KIND_PIC,
                                 frag_key_ff, ts_in);
                     n_push = 2'd1;
                  end
                  frag_open_in = 1'b1;
                  frag_key_in = (t5 == NAL_IDR);
                  frag_len_in = FLW'(1);
                  hdr = 1'b1;
               end
               if (!frag_open_in) begin
                  phase_in = PH_SKIP;
               end else begin
                  fsum = SW'(frag_len_in) + SW'(after);
                  if (fsum <= SW'(MAX_UNIT_BYTES)) begin
                     frag_len_in = FLW'(fsum);
                     skip_in = 1'b0;
                  end else begin
                     skip_in = 1'b1;
                  end
                  fu_end_in = b[6];
                  now_end = b[6] && (after == '0);
                  if (hdr || now_end) begin
                     if (n_push == 2'd0)
                        r0 = mk_res(hdr ? {nal_first_ff[7:5], t5} : 8'd0, hdr, hdr, now_end,
                                    1'b0, CODEC_264, KIND_PIC, frag_key_in, ts_in);
                     else
                        r1 = mk_res(hdr ? {nal_first_ff[7:5], t5} : 8'd0, hdr, hdr, now_end,
                                    1'b0, CODEC_264, KIND_PIC, frag_key_in, ts_in);
                     n_push = n_push + 2'd1;
                  end
                  if (now_end) begin
                     frag_open_in = 1'b0; frag_len_in = '0; fu_end_in = 1'b0; skip_in = 1'b0;
                  end
                  phase_in = (after != '0) ? PH_FU_BODY : PH_SKIP;
               end
            end
            PH_FU_BODY: begin
               en = (after == '0) && fu_end_ff;
               if (!skip_ff || en) begin
                  r0 = mk_res(skip_ff ? 8'd0 : b, !skip_ff, 1'b0, en, 1'b0, CODEC_264,
                              KIND_PIC, frag_key_ff, ts_in);
                  n_push = 2'd1;
               end
               if (en) begin
                  frag_open_in = 1'b0; frag_len_in = '0; fu_end_in = 1'b0; skip_in = 1'b0;
               end
            end
            PH_STAP_HI: begin
               acc_in = b;
               phase_in = PH_STAP_LO;
            end
            PH_STAP_LO: begin
               size = {acc_ff, b};
               if (size > 16'(after)) phase_in = PH_SKIP;
               else if (size == 16'd0) phase_in = PH_STAP_HI;
               else begin
                  sub_rem_in = size;
                  phase_in = PH_SUB_HEAD;
               end
            end
            PH_SUB_HEAD: begin
               do_264 = 1'b1; h_len = sub_rem_ff; h_stap = 1'b1;
            end
            PH_SUB_SKIP: begin
               sub_rem_in = sub_rem_ff - 16'd1;
               if (sub_rem_in == 16'd0) phase_in = PH_STAP_HI;
            end
            default: ;
         endcase
      end

      // NAL header of an H.264 unit
      if (do_264) begin
         if (t5 >= 5'd1 && t5 <= 5'd23) begin
            do_single = 1'b1; s_len = h_len; s_codec = CODEC_264; s_stap = h_stap;
            s_key = (t5 == NAL_IDR);
            if (t5 == NAL_SPS && h_len < 16'd256) s_kind = KIND_SPS;
            else if (t5 == NAL_PPS && h_len < 16'd64) s_kind = KIND_PPS;
         end else if (h_stap) begin
            sub_rem_in = h_len - 16'd1;
            phase_in = (sub_rem_in != 16'd0) ? PH_SUB_SKIP : PH_STAP_HI;
         end else if (t5 == NAL_STAP_A) begin
            phase_in = PH_STAP_HI;
         end else if (t5 == NAL_FU_A && h_len >= 16'd2) begin
            nal_first_in = b;
            phase_in = PH_FU_HDR;
         end else begin
            phase_in = PH_SKIP;
         end
      end

      if (do_265) begin
         if (h_len < 16'd2) begin
            phase_in = PH_SKIP;
         end else begin
            do_single = 1'b1; s_len = h_len; s_codec = CODEC_265; s_stap = 1'b0;
            s_key = (t6 >= 6'd16 && t6 <= 6'd21);
            if (t6 == HEVC_VPS && h_len < 16'd256) s_kind = KIND_VPS;
            else if (t6 == HEVC_SPS && h_len < 16'd256) s_kind = KIND_SPS;
            else if (t6 == HEVC_PPS && h_len < 16'd64) s_kind = KIND_PPS;
         end
      end

      if (do_single) begin
         cur_codec_in = s_codec; cur_kind_in = s_kind; cur_key_in = s_key;
         stap_in = s_stap;
         if (n_push == 2'd0)
            r0 = mk_res(b, 1'b1, 1'b1, s_len == 16'd1, 1'b0, s_codec, s_kind, s_key, ts_in);
         else
            r1 = mk_res(b, 1'b1, 1'b1, s_len == 16'd1, 1'b0, s_codec, s_kind, s_key, ts_in);
         n_push = n_push + 2'd1;
         if (s_len > 16'd1) begin
            live_in = 1'b1;
            sub_rem_in = s_len - 16'd1;
            phase_in = PH_SINGLE;
         end else begin
            phase_in = s_stap ? PH_STAP_HI : PH_SKIP;
         end
      end

      // advance the byte position; end of packet drops back to idle
      if (!no_step) begin
         pos_in = pos_in + 14'd1;
         if (pos_in >= pkt_len_in) begin
            phase_in = PH_IDLE;
            live_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; phase_ff <= PH_IDLE; hdr_len_ff <= '0; last_seq_ff <= '0;
         ts_ff <= '0; route_ff <= ROUTE_DROP; det_ff <= DET_NONE; nal_first_ff <= '0;
         sub_rem_ff <= '0; frag_open_ff <= 1'b0; frag_len_ff <= '0; frag_key_ff <= 1'b0;
         skip_ff <= 1'b0; pkt_len_ff <= '0; ext_ff <= 1'b0; acc_ff <= '0;
         live_ff <= 1'b0; stap_ff <= 1'b0; fu_end_ff <= 1'b0; cur_codec_ff <= 1'b0;
         cur_kind_ff <= KIND_PIC; cur_key_ff <= 1'b0;
      end else if (step) begin
         pos_ff <= pos_in; phase_ff <= phase_in; hdr_len_ff <= hdr_len_in;
         last_seq_ff <= last_seq_in; ts_ff <= ts_in; route_ff <= route_in;
         det_ff <= det_in; nal_first_ff <= nal_first_in; sub_rem_ff <= sub_rem_in;
         frag_open_ff <= frag_open_in; frag_len_ff <= frag_len_in;
         frag_key_ff <= frag_key_in; skip_ff <= skip_in; pkt_len_ff <= pkt_len_in;
         ext_ff <= ext_in; acc_ff <= acc_in; live_ff <= live_in; stap_ff <= stap_in;
         fu_end_ff <= fu_end_in; cur_codec_ff <= cur_codec_in;
         cur_kind_ff <= cur_kind_in; cur_key_ff <= cur_key_in;
      end
   end

endmodule

FILE: src/hdpk_queue.sv
// Result queue: takes up to two items per cycle, hands out one per beat.
module hdpk_queue import hdpk_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] n_push,
   input  res_type    r0,
   input  res_type    r1,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output res_type    out_item
);

   res_type        q_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPW:0]   cnt_ff, cnt_in;
   logic           pop;

   assign out_valid = (cnt_ff != '0);
   assign out_item  = q_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // keep space for the worst beat of two items
   assign room      = (cnt_ff <= (QPW+1)'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_in  = wr_ff + QPW'(n_push);
      rd_in  = pop ? rd_ff + QPW'(1) : rd_ff;
      cnt_in = cnt_ff + (QPW+1)'(n_push) - (QPW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) q_ff[wr_ff] <= r0;
      if (n_push == 2'd2) q_ff[wr_ff + QPW'(1)] <= r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: sim/rtp_h26x_nal_depacketizer_top_tb.sv
// Self-checking testbench: random RTP/raw packet streams vs. a cycle-free NAL item predictor.
module rtp_h26x_nal_depacketizer_top_tb;
   import hdpk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIT_CAP   = 262144;
   localparam int PACKET_CAP = 16384;

   typedef struct packed {
      logic [7:0]  b;
      logic [13:0] len;
      logic        first;
   } pkt_beat_type;

   typedef logic [7:0] bq_type[$];

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   hdpk_req_if req_if();
   hdpk_rsp_if rsp_if();

   rtp_h26x_nal_depacketizer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pkt_beat_type byte_feed_q[$];
   res_type      nal_expect_q[$];
   int           errors;
   bit           quiet;
   logic [15:0]  seq_next;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- predictor state
   bit          auto_det;
   int unsigned pos, hdr_len, last_seq, pkt_ts, plen, acc, sub_rem, frag_len;
   phase_type   phase;
   route_type   route;
   det_type     det;
   logic [7:0]  nal_fb;
   bit          ext_pend, frag_open, frag_key, skip_pl, single_live, in_stap, fu_end_pend;
   bit          cur_codec, cur_key;
   logic [1:0]  cur_kind;
   int          step_n;

   function automatic void push_item(logic [7:0] b, bit has, bit st, bit en, bit dr,
                                     bit codec, logic [1:0] kind, bit key);
      res_type r;
      if (step_n >= 3) return;
      r = '{b, has, st, en, dr, codec, kind, key, pkt_ts};
      nal_expect_q.push_back(r);
      step_n++;
   endfunction

   function automatic void drop_fragment();
      frag_open   = 0;
      frag_len    = 0;
      fu_end_pend = 0;
      skip_pl     = 0;
   endfunction

   function automatic int unsigned left_after();
      return (plen > pos + 1) ? plen - pos - 1 : 0;
   endfunction

   function automatic void open_single(logic [7:0] b, int unsigned len, bit codec,
                                       logic [1:0] kind, bit key, bit stap);
      cur_codec = codec;
      cur_kind  = kind;
      cur_key   = key;
      in_stap   = stap;
      push_item(b, 1, 1, len == 1, 0, codec, kind, key);
      if (len > 1) begin
         single_live = 1;
         sub_rem     = len - 1;
         phase       = PH_SINGLE;
      end else begin
         phase = stap ? PH_STAP_HI : PH_SKIP;
      end
   endfunction

   function automatic void avc_head(logic [7:0] b, int unsigned len, bit stap);
      logic [4:0] t;
      logic [1:0] kind;
      t = b[4:0];
      if (t >= 1 && t <= 23) begin
         kind = KIND_PIC;
         if (t == NAL_SPS && len < 256) kind = KIND_SPS;
         else if (t == NAL_PPS && len < 64) kind = KIND_PPS;
         open_single(b, len, CODEC_264, kind, t == NAL_IDR, stap);
      end else if (stap) begin
         sub_rem = len - 1;
         phase   = (sub_rem != 0) ? PH_SUB_SKIP : PH_STAP_HI;
      end else if (t == NAL_STAP_A) begin
         phase = PH_STAP_HI;
      end else if (t == NAL_FU_A && len >= 2) begin
         nal_fb = b;
         phase  = PH_FU_HDR;
      end else begin
         phase = PH_SKIP;
      end
   endfunction

   function automatic void hevc_head(logic [7:0] b, int unsigned len);
      logic [5:0] t;
      logic [1:0] kind;
      t    = b[6:1];
      kind = KIND_PIC;
      if (len < 2) begin
         phase = PH_SKIP;
         return;
      end
      if (t == HEVC_VPS && len < 256) kind = KIND_VPS;
      else if (t == HEVC_SPS && len < 256) kind = KIND_SPS;
      else if (t == HEVC_PPS && len < 64) kind = KIND_PPS;
      open_single(b, len, CODEC_265, kind, t >= 16 && t <= 21, 0);
   endfunction

   function automatic void rtp_header_done();
      if (plen <= hdr_len || route == ROUTE_DROP) phase = PH_SKIP;
      else det = (route == ROUTE_H264) ? DET_H264 : DET_H265;
   endfunction

   function automatic void rtp_field(logic [7:0] b);
      int unsigned seq, ext_len;
      logic [6:0]  pt;
      if (pos == 1) begin
         pt    = b[6:0];
         route = (pt == PT_H264) ? ROUTE_H264 : (pt == PT_H265) ? ROUTE_H265 : ROUTE_DROP;
      end else if (pos == 2) begin
         acc = b;
      end else if (pos == 3) begin
         seq = ((acc << 8) | b) & 32'hFFFF;
         // gap in the sequence: abandon an open fragment
         if (last_seq != 0 && seq != ((last_seq + 1) & 32'hFFFF)) begin
            if (frag_open) push_item(8'h00, 0, 0, 0, 1, CODEC_264, KIND_PIC, frag_key);
            drop_fragment();
         end
         last_seq = seq;
         if (ext_pend) begin
            if (plen < hdr_len + 4) phase = PH_SKIP;
         end else begin
            rtp_header_done();
         end
      end else if (pos >= 4 && pos <= 7) begin
         pkt_ts = (pkt_ts << 8) | b;
      end else if (ext_pend && pos == hdr_len + 2) begin
         acc = b;
      end else if (ext_pend && pos == hdr_len + 3) begin
         ext_len  = ((acc << 8) | b) & 32'hFFFF;
         hdr_len  = hdr_len + 4 + ext_len * 4;
         ext_pend = 0;
         rtp_header_done();
      end
      if (phase == PH_RTP && !ext_pend && pos + 1 == hdr_len) phase = PH_HEAD;
   endfunction

   function automatic void fu_hdr_byte(logic [7:0] b);
      int unsigned after;
      logic [4:0]  ft;
      bit          hdr, now_end;
      after = left_after();
      ft    = b[4:0];
      hdr   = 0;
      if (b[7]) begin
         // restart while open: close the old unit first
         if (frag_open) push_item(8'h00, 0, 0, 0, 1, CODEC_264, KIND_PIC, frag_key);
         frag_open = 1;
         frag_key  = (ft == NAL_IDR);
         frag_len  = 1;
         hdr       = 1;
      end
      if (!frag_open) begin
         phase = PH_SKIP;
         return;
      end
      if (frag_len + after <= UNIT_CAP) begin
         frag_len += after;
         skip_pl   = 0;
      end else begin
         skip_pl = 1;
      end
      fu_end_pend = b[6];
      now_end     = fu_end_pend && after == 0;
      if (hdr)
         push_item((nal_fb & 8'hE0) | ft, 1, 1, now_end, 0, CODEC_264, KIND_PIC, frag_key);
      else if (now_end)
         push_item(8'h00, 0, 0, 1, 0, CODEC_264, KIND_PIC, frag_key);
      if (now_end) drop_fragment();
      phase = (after != 0) ? PH_FU_BODY : PH_SKIP;
   endfunction

   function automatic void fu_body_byte(logic [7:0] b);
      bit en;
      en = (left_after() == 0) && fu_end_pend;
      if (!skip_pl) push_item(b, 1, 0, en, 0, CODEC_264, KIND_PIC, frag_key);
      else if (en) push_item(8'h00, 0, 0, 1, 0, CODEC_264, KIND_PIC, frag_key);
      if (en) drop_fragment();
   endfunction

   function automatic void predict_nal_items(pkt_beat_type bt);
      logic [7:0]  b;
      int unsigned len, size;
      bit          en;
      b      = bt.b;
      len    = bt.len;
      step_n = 0;
      if (bt.first) begin
         // truncated packet: close whatever it was feeding
         if (phase != PH_IDLE) begin
            if (single_live) begin
               push_item(8'h00, 0, 0, 0, 1, cur_codec, cur_kind, cur_key);
            end else if (frag_open && (phase == PH_FU_HDR || phase == PH_FU_BODY)) begin
               push_item(8'h00, 0, 0, 0, 1, CODEC_264, KIND_PIC, frag_key);
               drop_fragment();
            end
         end
         single_live = 0;
         in_stap     = 0;
         ext_pend    = 0;
         pos         = 0;
         plen        = len;
         route       = ROUTE_DROP;
         if (len < 12 || len > PACKET_CAP) begin
            phase = PH_SKIP;
         end else if (b[7:6] == 2'b10) begin
            phase    = PH_RTP;
            hdr_len  = 12 + b[3:0] * 4;
            ext_pend = b[4];
         end else if (det == DET_H264 || auto_det) begin
            route   = ROUTE_RAW;
            pkt_ts  = 0;
            hdr_len = 0;
            avc_head(b, len, 0);
         end else begin
            phase = PH_SKIP;
         end
      end else begin
         case (phase)
            PH_IDLE: return;
            PH_RTP: rtp_field(b);
            PH_HEAD: begin
               if (route == ROUTE_H265) hevc_head(b, plen - pos);
               else avc_head(b, plen - pos, 0);
            end
            PH_SINGLE: begin
               sub_rem = (sub_rem - 1) & 32'hFFFF;
               en      = (sub_rem == 0);
               push_item(b, 1, 0, en, 0, cur_codec, cur_kind, cur_key);
               if (en) begin
                  single_live = 0;
                  phase       = in_stap ? PH_STAP_HI : PH_SKIP;
               end
            end
            PH_FU_HDR: fu_hdr_byte(b);
            PH_FU_BODY: fu_body_byte(b);
            PH_STAP_HI: begin
               acc   = b;
               phase = PH_STAP_LO;
            end
            PH_STAP_LO: begin
               size = ((acc << 8) | b) & 32'hFFFF;
               if (size > left_after()) phase = PH_SKIP;
               else if (size == 0) phase = PH_STAP_HI;
               else begin
                  sub_rem = size;
                  phase   = PH_SUB_HEAD;
               end
            end
            PH_SUB_HEAD: avc_head(b, sub_rem, 1);
            PH_SUB_SKIP: begin
               sub_rem = (sub_rem - 1) & 32'hFFFF;
               if (sub_rem == 0) phase = PH_STAP_HI;
            end
            default: ;
         endcase
      end
      pos++;
      if (pos >= plen) begin
         phase       = PH_IDLE;
         single_live = 0;
      end
   endfunction

   // ---------------------------------------------------------------- driver
   pkt_beat_type cur_beat;
   int           send_gap;

   always @(posedge clock) begin
      bit go;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) predict_nal_items(cur_beat);
         if (!(req_if.valid && !req_if.ready)) begin
            go = 0;
            if (send_gap > 0) send_gap--;
            else if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12) - 1;
            else go = byte_feed_q.size() > 0;
            if (go) begin
               cur_beat = byte_feed_q.pop_front();
               req_if.valid           <= 1'b1;
               req_if.data_byte       <= cur_beat.b;
               req_if.packet_length   <= cur_beat.len;
               req_if.first_of_packet <= cur_beat.first;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   int stall_gap;

   task automatic report(input string what);
      errors++;
      if (errors <= 40) $display("mismatch @%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (nal_expect_q.size() == 0) begin
               report("unexpected result item");
            end else begin
               want = nal_expect_q.pop_front();
               if (rsp_if.out_byte !== want.out_byte)
                  report($sformatf("out_byte %h want %h", rsp_if.out_byte, want.out_byte));
               if (rsp_if.has_byte !== want.has_byte)
                  report($sformatf("has_byte %b want %b", rsp_if.has_byte, want.has_byte));
               if (rsp_if.unit_start !== want.unit_start)
                  report($sformatf("unit_start %b want %b", rsp_if.unit_start, want.unit_start));
               if (rsp_if.unit_end !== want.unit_end)
                  report($sformatf("unit_end %b want %b", rsp_if.unit_end, want.unit_end));
               if (rsp_if.unit_dropped !== want.unit_dropped)
                  report($sformatf("unit_dropped %b want %b", rsp_if.unit_dropped,
                                   want.unit_dropped));
               if (rsp_if.codec !== want.codec)
                  report($sformatf("codec %b want %b", rsp_if.codec, want.codec));
               if (rsp_if.unit_kind !== want.unit_kind)
                  report($sformatf("unit_kind %0d want %0d", rsp_if.unit_kind, want.unit_kind));
               if (rsp_if.keyframe !== want.keyframe)
                  report($sformatf("keyframe %b want %b", rsp_if.keyframe, want.keyframe));
               if (rsp_if.timestamp !== want.timestamp)
                  report($sformatf("timestamp %h want %h", rsp_if.timestamp, want.timestamp));
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_gap = $urandom_range(1, 12) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- packet building
   task automatic add_random(ref bq_type p, input int n);
      for (int i = 0; i < n; i++) p.push_back($urandom);
   endtask

   task automatic rtp_header(ref bq_type p, input logic [6:0] pt, input int cc,
                             input bit ext_on, input logic [15:0] ext_words);
      logic [31:0] ts;
      logic [7:0]  mk;
      ts = $urandom;
      mk = $urandom;
      p.push_back({2'b10, 1'b0, ext_on, cc[3:0]});
      p.push_back({mk[0], pt});
      if ($urandom_range(0, 11) == 0) seq_next += 16'($urandom_range(2, 40));
      p.push_back(seq_next[15:8]);
      p.push_back(seq_next[7:0]);
      seq_next++;
      for (int i = 3; i >= 0; i--) p.push_back(ts[8*i +: 8]);
      add_random(p, 4 + 4 * cc);
      if (ext_on) begin
         add_random(p, 2);
         p.push_back(ext_words[15:8]);
         p.push_back(ext_words[7:0]);
         add_random(p, 4 * ext_words);
      end
   endtask

   // extra > 0 declares a longer packet than is sent, so the next one truncates it
   task automatic ship(ref bq_type p, input int extra);
      int unsigned  n;
      pkt_beat_type bt;
      n = p.size() + extra;
      if (n > 16383) n = 16383;
      for (int i = 0; i < p.size(); i++) begin
         bt.b     = p[i];
         bt.first = (i == 0);
         bt.len   = (i == 0) ? 14'(n) : 14'($urandom);
         byte_feed_q.push_back(bt);
      end
   endtask

   task automatic avc_single(input logic [4:0] t, input int n, input int extra);
      bq_type p;
      logic [7:0] nri;
      nri = $urandom;
      rtp_header(p, PT_H264, 0, 0, 0);
      p.push_back({1'b0, nri[6:5], t});
      add_random(p, n);
      ship(p, extra);
   endtask

   task automatic hevc_single(input logic [5:0] t, input int n);
      bq_type p;
      logic [7:0] lb;
      lb = $urandom;
      rtp_header(p, PT_H265, 0, 0, 0);
      p.push_back({1'b0, t, lb[0]});
      if (n > 0) p.push_back(8'h01);
      add_random(p, n > 0 ? n - 1 : 0);
      ship(p, 0);
   endtask

   task automatic stap_packet(input bit nasty);
      bq_type p;
      int  k, sz;
      logic [4:0] t;
      rtp_header(p, PT_H264, 0, 0, 0);
      p.push_back(8'h18 | (8'h60 & 8'($urandom)));
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) begin
         sz = $urandom_range(1, 6);
         if (nasty && $urandom_range(0, 3) == 0) begin
            p.push_back(8'h00);
            p.push_back(8'h00);
         end
         t = $urandom_range(1, 23);
         if (nasty && $urandom_range(0, 2) == 0)
            t = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'd24 + 5'($urandom_range(0, 7));
         if ($urandom_range(0, 3) == 0) t = ($urandom_range(0, 1) != 0) ? NAL_SPS : NAL_PPS;
         p.push_back(8'(sz >> 8));
         p.push_back(8'(sz));
         p.push_back({3'b011, t});
         add_random(p, sz - 1);
      end
      if (nasty && $urandom_range(0, 1) == 0) begin
         p.push_back(8'h00);
         p.push_back(8'h40);
         add_random(p, 2);
      end
      ship(p, 0);
   endtask

   // brk: 0 clean, 1 no start, 2 lost fragment, 3 restart, 4 truncated last fragment
   task automatic fu_unit(input int nfrag, input logic [4:0] ft, input int brk);
      bq_type p;
      logic [7:0] hdr;
      for (int f = 0; f < nfrag; f++) begin
         p = {};
         if (brk == 2 && f == 1) seq_next += 16'd3;
         rtp_header(p, PT_H264, 0, 0, 0);
         p.push_back(8'h1C | (8'h60 & 8'($urandom)));
         hdr = {3'b000, ft};
         if ((f == 0 && brk != 1) || (brk == 3 && f == 1)) hdr[7] = 1'b1;
         if (f == nfrag - 1) hdr[6] = 1'b1;
         p.push_back(hdr);
         add_random(p, $urandom_range(0, 6));
         ship(p, (brk == 4 && f == nfrag - 1) ? 4 : 0);
      end
   endtask

   task automatic raw_packet(input logic [7:0] b0, input int n, input int extra);
      bq_type p;
      p.push_back(b0);
      add_random(p, n);
      ship(p, extra);
   endtask

   task automatic random_packet();
      bq_type p;
      logic [7:0] b0;
      logic [4:0] pick5[4];
      logic [5:0] pick6[6];
      pick5 = '{NAL_IDR, NAL_SPS, NAL_PPS, 5'd1};
      pick6 = '{HEVC_VPS, HEVC_SPS, HEVC_PPS, 6'd19, 6'd1, 6'($urandom_range(0, 63))};
      case ($urandom_range(0, 15))
         0, 1: avc_single(pick5[$urandom_range(0, 3)], $urandom_range(0, 12), 0);
         2: avc_single(5'($urandom_range(1, 23)), $urandom_range(0, 12), 0);
         3, 4: stap_packet($urandom_range(0, 2) == 0);
         5, 6, 7: fu_unit($urandom_range(1, 4), ($urandom_range(0, 1) != 0) ? NAL_IDR : 5'd1,
                          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
         8, 9: hevc_single(pick6[$urandom_range(0, 5)], $urandom_range(0, 10));
         10: begin
            b0 = $urandom;
            if (b0[7:6] == 2'b10) b0[7] = 1'b0;
            raw_packet(b0, $urandom_range(11, 20), 0);
         end
         11: begin
            add_random(p, $urandom_range(0, 11));
            if (p.size() == 0) p.push_back($urandom);
            ship(p, 0);
            p.delete(0);
         end
         12: begin
            rtp_header(p, 7'($urandom_range(0, 127)), $urandom_range(0, 2), 0, 0);
            add_random(p, $urandom_range(1, 5));
            ship(p, 0);
         end
         13: avc_single(5'($urandom_range(1, 23)), $urandom_range(2, 10), $urandom_range(1, 5));
         14: begin
            rtp_header(p, PT_H264, $urandom_range(0, 1), 1, 16'($urandom_range(0, 2)));
            p.push_back(8'h41);
            add_random(p, $urandom_range(0, 4));
            ship(p, 0);
         end
         default: begin
            // stray bytes outside any packet
            add_random(p, $urandom_range(1, 3));
            foreach (p[i]) byte_feed_q.push_back('{p[i], 14'($urandom), 1'b0});
         end
      endcase
   endtask

   // ---------------------------------------------------------------- sequencing
   task automatic drain();
      while (byte_feed_q.size() != 0 || req_if.valid || nal_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_auto(input bit v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      auto_det     = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int nbytes);
      int start;
      start = byte_feed_q.size();
      while (byte_feed_q.size() - start < nbytes) random_packet();
   endtask

   initial begin
      bq_type p;
      errors      = 0;
      quiet       = 0;
      seq_next    = 16'd100;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      req_if.valid           = 1'b0;
      req_if.data_byte       = '0;
      req_if.packet_length   = '0;
      req_if.first_of_packet = 1'b0;
      rsp_if.ready           = 1'b0;
      auto_det    = 1;
      pos = 0; hdr_len = 0; last_seq = 0; pkt_ts = 0; plen = 0; acc = 0;
      sub_rem = 0; frag_len = 0; phase = PH_IDLE; route = ROUTE_DROP; det = DET_NONE;
      nal_fb = 0; ext_pend = 0; frag_open = 0; frag_key = 0; skip_pl = 0;
      single_live = 0; in_stap = 0; fu_end_pend = 0;
      cur_codec = 0; cur_key = 0; cur_kind = KIND_PIC;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray bytes before any packet, raw units, parameter sets, fragments
      byte_feed_q.push_back('{8'hFF, 14'h3FFF, 1'b0});
      raw_packet(8'h65, 11, 0);
      avc_single(NAL_SPS, 3, 0);
      avc_single(NAL_IDR, 0, 0);
      stap_packet(1);
      fu_unit(2, NAL_IDR, 0);
      fu_unit(2, NAL_IDR, 3);
      rtp_header(p, PT_H264, 0, 0, 0);
      p.push_back(8'h1C);
      ship(p, 0);
      p = {};
      hevc_single(HEVC_VPS, 2);
      rtp_header(p, PT_H264, 2, 0, 0);
      ship(p, 0);
      p = {};
      rtp_header(p, PT_H264, 0, 1, 16'hFFFF);
      p = p[0:15];
      p.push_back(8'h41);
      ship(p, 0);
      p = {};
      p.push_back(8'h90);
      add_random(p, 11);
      ship(p, 0);
      p = {};
      avc_single(NAL_SPS, 10, 16383);
      seq_next = 16'hFFFF;
      avc_single(5'd1, 0, 0);
      avc_single(5'd1, 0, 0);
      drain();

      write_auto(1'b0);
      random_phase(20);
      drain();

      write_auto(1'b1);
      random_phase(20);
      drain();

      write_auto(1'b0);
      quiet = 1;
      random_phase(15);
      drain();
      repeat (20) @(posedge clock);

      if (nal_expect_q.size() != 0) report($sformatf("%0d items never came", nal_expect_q.size()));
      if (errors == 0) begin
         $display("** rtp_h26x_nal_depacketizer_top: PASSED **");
      end else begin
         $display("** rtp_h26x_nal_depacketizer_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #(50_000_000);
      $display("timeout waiting for results");
      $display("** rtp_h26x_nal_depacketizer_top: FAILED **");
      $finish;
   end

endmodule
